[design/hxt_pkg.sv]
package hxt_pkg;

	localparam int MAX_COLS = 32;
	localparam int MAX_ROWS = 32;
	localparam int COORD_W  = 5;
	localparam int SIZE_W   = 6;
	localparam int DIR_W    = 3;
	localparam int KIND_W   = 2;
	localparam int DEPTH    = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int STEPS_W  = $clog2(COORD_W + 1);
	localparam int REG_IDX_W = 1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

	localparam logic [DIR_W-1:0] DIR_UP         = 3'd0;
	localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 3'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN       = 3'd3;
	localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 3'd4;
	localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 3'd5;
	localparam logic [DIR_W-1:0] NUM_SIDES      = 3'd6;

	localparam logic [SIZE_W-1:0] RESET_SIZE = 6'd32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_COL,
		ST_MOD_ROW,
		ST_MOVE,
		ST_LOOK,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} pos_t;

	// remainder unit request
	typedef struct packed {
		logic               load;
		logic [COORD_W-1:0] num;
		logic [SIZE_W-1:0]  den;
	} rem_req_t;

	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] rem;
	} rem_stat_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KIND_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) r = SIZE_W'(1);
		else if (v > SIZE_W'(maxv)) r = SIZE_W'(maxv);
		else r = v;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(pos_t p);
		return ADDR_W'(ADDR_W'(p.row) * ADDR_W'(MAX_COLS) + ADDR_W'(p.col));
	endfunction

	function automatic logic [COORD_W-1:0] inc_wrap(logic [COORD_W-1:0] v,
			logic [SIZE_W-1:0] n);
		logic [SIZE_W-1:0] s;
		s = {1'b0, v} + SIZE_W'(1);
		return (s >= n) ? '0 : s[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] dec_wrap(logic [COORD_W-1:0] v,
			logic [SIZE_W-1:0] n);
		logic [SIZE_W-1:0] t;
		t = n - SIZE_W'(1);
		return (v == '0) ? t[COORD_W-1:0] : v - COORD_W'(1);
	endfunction

	// odd rows sit half a cell lower, so diagonal moves shift by row parity
	function automatic pos_t hex_next(pos_t p, logic [DIR_W-1:0] side,
			logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
		pos_t n;
		logic odd;
		n = p;
		odd = p.row[0];
		case (side)
			DIR_UP: begin
				n.row = dec_wrap(p.row, h);
			end
			DIR_UP_RIGHT: begin
				n.col = inc_wrap(p.col, w);
				if (!odd) n.row = dec_wrap(p.row, h);
			end
			DIR_DOWN_RIGHT: begin
				n.col = inc_wrap(p.col, w);
				if (odd) n.row = inc_wrap(p.row, h);
			end
			DIR_DOWN: begin
				n.row = inc_wrap(p.row, h);
			end
			DIR_DOWN_LEFT: begin
				n.col = dec_wrap(p.col, w);
				if (odd) n.row = inc_wrap(p.row, h);
			end
			DIR_UP_LEFT: begin
				n.col = dec_wrap(p.col, w);
				if (!odd) n.row = dec_wrap(p.row, h);
			end
			default: begin
				n = p;
			end
		endcase
		return n;
	endfunction

endpackage

[design/hxt_rem_unit.sv]
// Restoring remainder, one quotient bit per cycle through one subtractor.
module hxt_rem_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  hxt_pkg::rem_req_t  req,
	output hxt_pkg::rem_stat_t stat
);

	logic                             active_q;
	logic                             done_q;
	logic [hxt_pkg::STEPS_W-1:0]      cnt_q;
	logic [hxt_pkg::COORD_W-1:0]      num_q;
	logic [hxt_pkg::SIZE_W-1:0]       den_q;
	logic [hxt_pkg::COORD_W-1:0]      rem_q;
	logic [hxt_pkg::SIZE_W-1:0]       shifted;
	logic [hxt_pkg::SIZE_W-1:0]       diff;
	logic [hxt_pkg::COORD_W-1:0]      rem_next;

	always_comb begin
		shifted = {rem_q, num_q[hxt_pkg::COORD_W-1]};
		diff = shifted - den_q;
		rem_next = (shifted >= den_q) ? diff[hxt_pkg::COORD_W-1:0]
			: shifted[hxt_pkg::COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.load) begin
			active_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= hxt_pkg::STEPS_W'(hxt_pkg::COORD_W);
		end else if (active_q) begin
			cnt_q <= cnt_q - hxt_pkg::STEPS_W'(1);
			if (cnt_q == hxt_pkg::STEPS_W'(1)) begin
				active_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (active_q) begin
			num_q <= {num_q[hxt_pkg::COORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign stat.done = done_q;
	assign stat.rem = rem_q;

endmodule

[design/hxt_cell_store.sv]
module hxt_cell_store (
	input  logic                       clk,
	input  hxt_pkg::mem_req_t          req,
	output logic [hxt_pkg::KIND_W-1:0] rdata
);

	logic [hxt_pkg::KIND_W-1:0] mem_q [hxt_pkg::DEPTH];
	logic [hxt_pkg::KIND_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) mem_q[req.waddr] <= req.wdata;
	end

	always_ff @(posedge clk) begin
		if (req.re) rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/hex_torus_ray_distance_unit.sv]
// Distance walk on a wrapping hex grid with offset rows. A write request stores one cell
// kind and gives no result. A query request first reduces col and row modulo the grid
// size in one shared remainder unit, column first and then row, then takes the first step
// and walks one cell at a time (registered read of the cell store read port, then check).
// The walk ends on a compute or empty cell, or when the step count reaches the grid width;
// direction codes 6 and 7 finish straight after the first-step state, with no walk. in_ready
// is low while a query runs; a finished result waits in the output register, and a later
// query waits in its finishing state until that register frees.
// Cell kinds are not cleared at reset: load every cell before the first query.
module hex_torus_ray_distance_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hxt_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [hxt_pkg::SIZE_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [hxt_pkg::COORD_W-1:0]       col,
	input  logic [hxt_pkg::COORD_W-1:0]       row,
	input  logic [hxt_pkg::DIR_W-1:0]         direction,
	input  logic [hxt_pkg::KIND_W-1:0]        cell_kind,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hxt_pkg::COORD_W-1:0]       distance,
	output logic [hxt_pkg::COORD_W-1:0]       first_col,
	output logic [hxt_pkg::COORD_W-1:0]       first_row
);

	hxt_pkg::state_t  state_q, state_d;
	hxt_pkg::rem_req_t  rem_req;
	hxt_pkg::rem_stat_t rem_stat;
	hxt_pkg::mem_req_t  mem_req;
	logic [hxt_pkg::KIND_W-1:0] rdata;

	logic [hxt_pkg::SIZE_W-1:0]  grid_width_q, grid_height_q;
	logic [hxt_pkg::SIZE_W-1:0]  w_q, h_q;
	logic [hxt_pkg::DIR_W-1:0]   dir_q;
	logic [hxt_pkg::COORD_W-1:0] row_q;
	hxt_pkg::pos_t               start_q, pos_q, first_q, next_pos;
	logic [hxt_pkg::SIZE_W-1:0]  step_q;
	logic [hxt_pkg::COORD_W-1:0] dist_q;
	logic                        out_valid_q;
	logic [hxt_pkg::COORD_W-1:0] distance_q, first_col_q, first_row_q;
	logic                        in_acc, wr_acc, qry_acc, out_load, wr_in_range;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == hxt_pkg::ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign wr_acc = in_acc && (cmd == hxt_pkg::CMD_WRITE);
	assign qry_acc = in_acc && (cmd == hxt_pkg::CMD_QUERY);
	assign wr_in_range = ({1'b0, col} < hxt_pkg::SIZE_W'(hxt_pkg::MAX_COLS))
		&& ({1'b0, row} < hxt_pkg::SIZE_W'(hxt_pkg::MAX_ROWS));
	assign out_load = (state_q == hxt_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign next_pos = hxt_pkg::hex_next(pos_q, dir_q, w_q, h_q);

	hxt_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.stat   (rem_stat)
	);

	hxt_cell_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hxt_pkg::ST_IDLE;
			grid_width_q <= hxt_pkg::RESET_SIZE;
			grid_height_q <= hxt_pkg::RESET_SIZE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == hxt_pkg::REG_GRID_WIDTH) grid_width_q <= cfg_data;
				else if (cfg_index == hxt_pkg::REG_GRID_HEIGHT) grid_height_q <= cfg_data;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		rem_req = '0;
		mem_req = '0;
		mem_req.we = wr_acc && wr_in_range;
		mem_req.waddr = hxt_pkg::cell_addr('{col: col, row: row});
		mem_req.wdata = cell_kind;
		mem_req.raddr = hxt_pkg::cell_addr(pos_q);
		case (state_q)
			hxt_pkg::ST_IDLE: begin
				if (qry_acc) begin
					rem_req.load = 1'b1;
					rem_req.num = col;
					rem_req.den = hxt_pkg::clamp_size(grid_width_q, hxt_pkg::MAX_COLS);
					state_d = hxt_pkg::ST_MOD_COL;
				end
			end
			hxt_pkg::ST_MOD_COL: begin
				if (rem_stat.done) begin
					rem_req.load = 1'b1;
					rem_req.num = row_q;
					rem_req.den = h_q;
					state_d = hxt_pkg::ST_MOD_ROW;
				end
			end
			hxt_pkg::ST_MOD_ROW: begin
				if (rem_stat.done) state_d = hxt_pkg::ST_MOVE;
			end
			hxt_pkg::ST_MOVE: begin
				state_d = (dir_q < hxt_pkg::NUM_SIDES) ? hxt_pkg::ST_LOOK : hxt_pkg::ST_DONE;
			end
			hxt_pkg::ST_LOOK: begin
				if (step_q >= w_q) begin
					state_d = hxt_pkg::ST_DONE;
				end else begin
					mem_req.re = 1'b1;
					state_d = hxt_pkg::ST_CHECK;
				end
			end
			hxt_pkg::ST_CHECK: begin
				if (rdata == hxt_pkg::KIND_COMPUTE || rdata == hxt_pkg::KIND_EMPTY)
					state_d = hxt_pkg::ST_DONE;
				else
					state_d = hxt_pkg::ST_LOOK;
			end
			hxt_pkg::ST_DONE: begin
				if (out_load) state_d = hxt_pkg::ST_IDLE;
			end
			default: begin
				state_d = hxt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			hxt_pkg::ST_IDLE: begin
				if (qry_acc) begin
					w_q <= hxt_pkg::clamp_size(grid_width_q, hxt_pkg::MAX_COLS);
					h_q <= hxt_pkg::clamp_size(grid_height_q, hxt_pkg::MAX_ROWS);
					dir_q <= direction;
					row_q <= row;
					dist_q <= '0;
				end
			end
			hxt_pkg::ST_MOD_COL: begin
				if (rem_stat.done) start_q.col <= rem_stat.rem;
			end
			hxt_pkg::ST_MOD_ROW: begin
				if (rem_stat.done) start_q.row <= rem_stat.rem;
			end
			hxt_pkg::ST_MOVE: begin
				// first neighbor; no move for direction codes past the six sides
				first_q <= hxt_pkg::hex_next(start_q, dir_q, w_q, h_q);
				pos_q <= hxt_pkg::hex_next(start_q, dir_q, w_q, h_q);
				step_q <= hxt_pkg::SIZE_W'(1);
			end
			hxt_pkg::ST_CHECK: begin
				if (rdata == hxt_pkg::KIND_COMPUTE) begin
					dist_q <= step_q[hxt_pkg::COORD_W-1:0];
				end else if (rdata != hxt_pkg::KIND_EMPTY) begin
					pos_q <= next_pos;
					step_q <= step_q + hxt_pkg::SIZE_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			distance_q <= dist_q;
			first_col_q <= first_q.col;
			first_row_q <= first_q.row;
		end
	end

	assign out_valid = out_valid_q;
	assign distance = distance_q;
	assign first_col = first_col_q;
	assign first_row = first_row_q;

	// a result appears only from the finishing state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == hxt_pkg::ST_DONE))
		else $error("result loaded outside finish state");

	// the walk stays inside the grid in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hxt_pkg::ST_LOOK) |->
			({1'b0, pos_q.col} < w_q) && ({1'b0, pos_q.row} < h_q))
		else $error("walk position outside grid");

	// a cell is checked only within the step limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hxt_pkg::ST_CHECK) |-> (step_q < w_q) && $past(mem_req.re))
		else $error("cell check without a read in range");

	// the store is written only between queries
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != hxt_pkg::ST_IDLE) |-> !mem_req.we)
		else $error("cell write during a query");

endmodule
